>>> rtl/xfb_pkg.sv
package xfb_pkg;

  localparam int WIDTH  = 64;
  localparam int HEIGHT = 32;
  localparam int NPIX   = WIDTH * HEIGHT;
  localparam int AW     = $clog2(NPIX);
  localparam int XW     = 6;
  localparam int YW     = 5;
  localparam int DW     = 4;

  typedef enum logic [1:0] {
    OP_TOGGLE = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_TICK   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP,
    ST_LAST,
    ST_RD,
    ST_WB,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic          on;
    logic          vis;
    logic [DW-1:0] dly;
  } pix_t;

endpackage

>>> rtl/xor_framebuffer_delayed_off.sv
// XOR-draw monochrome framebuffer (64 x 32) with a per-pixel off-delay that keeps a
// pixel lit for off_delay frame ticks after it is turned off; the tick after that darkens it.
// All pixel state lives in one single-port-write, registered-read memory served by a
// small sequencer. After reset a clearing pass writes every pixel before the first
// transaction is accepted; off_delay may be written at any time. Toggle and read pass
// through the RD, WB and RESP states after acceptance. Clear and tick walk every pixel
// through a pipelined read-modify-write on the memory port, one pixel a cycle, then
// pass through LAST, RD, WB and RESP. In RESP the result moves to the output register
// once it is free. One transaction is in progress at a time; a finished result waits in
// the output register while the next transaction is accepted.
module xor_framebuffer_delayed_off
  import xfb_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    op,
  input  logic [XW-1:0] x,
  input  logic [YW-1:0] y,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          pixel_on,
  output logic          pixel_visible,
  output logic          done_res,
  input  logic          cfg_we,
  input  logic [DW-1:0] cfg_data
);

  state_t        state, state_next;
  logic [DW-1:0] off_delay;
  op_t           cur_op;
  logic [AW-1:0] pix_addr;
  logic          in_range;
  logic [AW-1:0] cnt;
  logic [AW-1:0] sw_addr;
  logic          sw_vld;
  logic          res_on, res_vis;

  pix_t          mem [NPIX];
  pix_t          rdata;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  pix_t          wdata;
  pix_t          sweep_pix;
  pix_t          tog_pix;
  logic          last;
  logic          in_fire;
  logic          in_range_in;
  logic [AW-1:0] addr_in;

  assign in_fire     = in_valid && in_ready;
  assign last        = (cnt == AW'(NPIX - 1));
  assign in_range_in = (32'(x) < WIDTH) && (32'(y) < HEIGHT);
  assign addr_in     = AW'(32'(y) * WIDTH + 32'(x));

  // memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    sweep_pix = rdata;
    if (cur_op == OP_CLEAR) begin
      sweep_pix.on  = 1'b0;
      sweep_pix.dly = off_delay;
    end else if (rdata.dly != '0) begin
      sweep_pix.dly = rdata.dly - DW'(1);
    end else if (!rdata.on) begin
      sweep_pix.vis = 1'b0;
    end
  end

  always_comb begin
    tog_pix = rdata;
    if (!rdata.on) begin
      tog_pix.on  = 1'b1;
      tog_pix.vis = 1'b1;
    end else begin
      tog_pix.on  = 1'b0;
      tog_pix.dly = off_delay;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT:  if (last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) begin
          unique case (op_t'(op))
            OP_CLEAR, OP_TICK:  state_next = ST_SWEEP;
            OP_TOGGLE, OP_READ: state_next = ST_RD;
            default:            state_next = ST_RD;
          endcase
        end
      end
      ST_SWEEP: if (last) state_next = ST_LAST;
      ST_LAST:  state_next = ST_RD;
      ST_RD:    state_next = ST_WB;
      ST_WB:    state_next = ST_RESP;
      ST_RESP:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = (state == ST_IDLE);
    raddr    = (state == ST_SWEEP) ? cnt : pix_addr;
    we       = 1'b0;
    waddr    = pix_addr;
    wdata    = tog_pix;
    unique case (state)
      ST_INIT: begin
        we    = 1'b1;
        waddr = cnt;
        wdata = '0;
      end
      ST_SWEEP, ST_LAST: begin
        we    = sw_vld;
        waddr = sw_addr;
        wdata = sweep_pix;
      end
      ST_WB: begin
        we = (cur_op == OP_TOGGLE) && in_range;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      off_delay <= DW'(1);
      cnt       <= '0;
      sw_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        off_delay <= cfg_data;
      end
      sw_vld <= (state == ST_SWEEP);
      if (state == ST_INIT || state == ST_SWEEP) begin
        cnt <= last ? '0 : cnt + AW'(1);
      end
      if (state == ST_RESP && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sw_addr <= cnt;
    if (in_fire) begin
      cur_op   <= op_t'(op);
      pix_addr <= addr_in;
      in_range <= in_range_in;
    end
    if (state == ST_WB) begin
      if (cur_op == OP_TOGGLE) begin
        res_on  <= in_range && tog_pix.on;
        res_vis <= in_range && tog_pix.vis;
      end else begin
        res_on  <= in_range && rdata.on;
        res_vis <= in_range && rdata.vis;
      end
    end
    if (state == ST_RESP && (!out_valid || out_ready)) begin
      pixel_on      <= res_on;
      pixel_visible <= res_vis;
    end
  end

  assign done_res = 1'b1;

endmodule

>>> tb/sv/xor_framebuffer_delayed_off_tb.sv
`timescale 1ns / 100ps

module xor_framebuffer_delayed_off_tb;
  import xfb_pkg::*;

  typedef struct packed {
    op_t           op;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
  } fb_cmd_t;

  typedef struct packed {
    logic on;
    logic vis;
    logic done;
  } fb_view_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [1:0]    op = 2'd0;
  logic [XW-1:0] x = '0;
  logic [YW-1:0] y = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic          pixel_on;
  logic          pixel_visible;
  logic          done_res;
  logic          cfg_we = 1'b0;
  logic [DW-1:0] cfg_data = '0;

  // shadow copy of the pixel store
  logic          fb_on  [NPIX];
  logic          fb_vis [NPIX];
  logic [DW-1:0] fb_dly [NPIX];
  logic [DW-1:0] cur_off_delay;

  fb_cmd_t  cmd_q[$];
  fb_view_t view_q[$];

  int   mismatch_count = 0;
  int   send_gap = 0;
  int   recv_gap = 0;
  logic calm = 1'b0;
  logic hold_go = 1'b0;
  logic long_hold = 1'b0;

  xor_framebuffer_delayed_off u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .x             (x),
    .y             (y),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_on      (pixel_on),
    .pixel_visible (pixel_visible),
    .done_res      (done_res),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic fb_view_t apply_op(op_t o, logic [XW-1:0] px, logic [YW-1:0] py);
    int       idx;
    int       i;
    logic     inside_fb;
    fb_view_t v;
    inside_fb = (int'(px) < WIDTH) && (int'(py) < HEIGHT);
    idx = inside_fb ? int'(py) * WIDTH + int'(px) : 0;
    case (o)
      OP_TOGGLE: begin
        if (inside_fb) begin
          if (!fb_on[idx]) begin
            fb_on[idx]  = 1'b1;
            fb_vis[idx] = 1'b1;
          end else begin
            fb_on[idx]  = 1'b0;
            fb_dly[idx] = cur_off_delay;
          end
        end
      end
      OP_CLEAR: begin
        for (i = 0; i < NPIX; i++) begin
          fb_on[i]  = 1'b0;
          fb_dly[i] = cur_off_delay;
        end
      end
      OP_TICK: begin
        for (i = 0; i < NPIX; i++) begin
          if (fb_dly[i] != '0) fb_dly[i] = fb_dly[i] - 1'b1;
          else if (!fb_on[i]) fb_vis[i] = 1'b0;
        end
      end
      default: ;
    endcase
    v.on   = inside_fb ? fb_on[idx] : 1'b0;
    v.vis  = inside_fb ? fb_vis[idx] : 1'b0;
    v.done = 1'b1;
    return v;
  endfunction

  // sender
  always @(posedge clk) begin
    fb_cmd_t c;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        c = cmd_q.pop_front();
        in_valid <= 1'b1;
        op       <= c.op;
        x        <= c.x;
        y        <= c.y;
        if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 18);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (recv_gap > 0) recv_gap--;
      else if (!calm && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 18);
      out_ready <= !long_hold && (recv_gap == 0);
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (5000) @(posedge clk);
    long_hold <= 1'b0;
  end

  // result check, then prediction for the transaction taken at this edge
  always @(posedge clk) begin
    fb_view_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (view_q.size() == 0) begin
          $error("result with no pending transaction");
          mismatch_count++;
        end else begin
          want = view_q.pop_front();
          if (pixel_on !== want.on) begin
            $error("pixel_on expected %0b got %0b", want.on, pixel_on);
            mismatch_count++;
          end
          if (pixel_visible !== want.vis) begin
            $error("pixel_visible expected %0b got %0b", want.vis, pixel_visible);
            mismatch_count++;
          end
          if (done_res !== want.done) begin
            $error("done_res expected %0b got %0b", want.done, done_res);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) view_q.push_back(apply_op(op_t'(op), x, y));
    end
  end

  task automatic push_cmd(op_t o, int px, int py);
    fb_cmd_t c;
    c.op = o;
    c.x  = px[XW-1:0];
    c.y  = py[YW-1:0];
    cmd_q.push_back(c);
  endtask

  task automatic settle();
    do begin
      @(posedge clk);
      #1;
    end while (cmd_q.size() != 0 || in_valid || view_q.size() != 0);
  endtask

  task automatic run_phase(logic [DW-1:0] dly, int n);
    int   k;
    int   r;
    int   px;
    int   py;
    op_t  o;
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= dly;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_off_delay = dly;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40) o = OP_TOGGLE;
      else if (r < 75) o = OP_READ;
      else if (r < 93) o = OP_TICK;
      else o = OP_CLEAR;
      // mostly a small set of pixels so toggles and reads keep hitting live state
      if ($urandom_range(0, 3) != 0) begin
        px = $urandom_range(0, 3) * 21;
        py = $urandom_range(0, 3) * 10 + 1;
      end else begin
        px = $urandom_range(0, WIDTH - 1);
        py = $urandom_range(0, HEIGHT - 1);
      end
      push_cmd(o, px, py);
    end
    settle();
  endtask

  initial begin
    for (int i = 0; i < NPIX; i++) begin
      fb_on[i]  = 1'b0;
      fb_vis[i] = 1'b0;
      fb_dly[i] = '0;
    end
    cur_off_delay = 4'd1;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed, off_delay at reset value
    push_cmd(OP_READ,    0,  0);
    push_cmd(OP_TOGGLE,  0,  0);
    push_cmd(OP_TOGGLE, 63, 31);
    push_cmd(OP_READ,   63, 31);
    push_cmd(OP_TOGGLE,  0,  0);
    push_cmd(OP_TICK,    0,  0);
    push_cmd(OP_READ,    0,  0);
    push_cmd(OP_TICK,    0,  0);
    push_cmd(OP_TOGGLE, 63, 31);
    push_cmd(OP_TOGGLE, 63, 31);   // back on, delay kept
    push_cmd(OP_TICK,   63, 31);
    push_cmd(OP_TOGGLE, 63, 31);
    push_cmd(OP_TICK,   63, 31);
    push_cmd(OP_TICK,   63, 31);
    push_cmd(OP_TOGGLE, 32, 16);
    push_cmd(OP_TOGGLE, 31, 15);
    push_cmd(OP_CLEAR,  32, 16);   // off but still visible
    push_cmd(OP_READ,   31, 15);
    push_cmd(OP_TICK,    0,  0);
    push_cmd(OP_TICK,   32, 16);
    push_cmd(OP_READ,   31, 15);
    push_cmd(OP_TOGGLE,  0,  0);
    push_cmd(OP_TICK,    0,  0);
    push_cmd(OP_READ,   42, 21);
    settle();

    run_phase(4'd0, 53);
    hold_go = 1'b1;
    run_phase(4'd15, 53);
    run_phase(4'($urandom_range(2, 14)), 53);
    run_phase(4'd1, 53);
    calm = 1'b1;
    run_phase(4'd7, 53);

    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #12000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
rtl/xfb_pkg.sv
rtl/xor_framebuffer_delayed_off.sv
tb/sv/xor_framebuffer_delayed_off_tb.sv
